// File: rtl/core/bsmm_pkg.sv
// Package for the bank switched memory mapper: request/response types,
// operation codes and decode constants. No dependencies.
package bsmm_pkg;

    localparam logic [1:0] OP_MEM_READ   = 2'd0;
    localparam logic [1:0] OP_MEM_WRITE  = 2'd1;
    localparam logic [1:0] OP_PORT_WRITE = 2'd2;
    localparam logic [1:0] OP_PORT_READ  = 2'd3;

    localparam int          NUM_ROWS      = 8;
    localparam int          OFFSET_W      = 14;
    localparam logic [13:0] SCREEN_BYTES  = 14'd6912;
    localparam logic [2:0]  SCREEN_BANK   = 3'd5;
    localparam logic [2:0]  SHADOW_BANK   = 3'd7;
    localparam logic [2:0]  SLOT1_BANK    = 3'd5;
    localparam logic [2:0]  SLOT2_BANK    = 3'd2;
    localparam logic [2:0]  BORDER_RESET  = 3'd2;

    // paging register and ULA port bit positions
    localparam int PG_SHADOW = 3;
    localparam int PG_ROM    = 4;
    localparam int PG_LOCK   = 5;
    localparam int ULA_BEEP  = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [63:0] key_rows;
    } bsmm_req_t;

    typedef struct packed {
        logic        is_rom;
        logic [16:0] phys_address;
        logic        write_enable;
        logic        screen_write;
        logic [7:0]  port_read_data;
        logic        shadow_screen;
        logic [2:0]  border_colour;
        logic        beeper_level;
        logic        paging_locked;
    } bsmm_rsp_t;

    typedef struct packed {
        logic [7:0] paging;
        logic [2:0] border;
        logic       beeper;
    } bsmm_state_t;

endpackage

// File: rtl/core/bsmm_decode.sv
// Access decode for the bank switched memory mapper: address translation,
// port decode, keyboard read and next machine state. Uses bsmm_pkg.
module bsmm_decode (
    input  bsmm_pkg::bsmm_req_t   req,
    input  bsmm_pkg::bsmm_state_t cur,
    output bsmm_pkg::bsmm_state_t nxt,
    output bsmm_pkg::bsmm_rsp_t   rsp
);
    import bsmm_pkg::*;

    logic [1:0]          slot;
    logic [OFFSET_W-1:0] offset;
    logic [2:0]          bank;
    logic [2:0]          shown;
    logic                paging_hit;
    logic                ula_hit;
    logic [7:0]          kbd;

    assign slot   = req.address[15:14];
    assign offset = req.address[OFFSET_W-1:0];
    assign shown  = cur.paging[PG_SHADOW] ? SHADOW_BANK : SCREEN_BANK;

    // A15=0, A1=0 selects paging; A0=0 selects border/beeper and keyboard
    assign paging_hit = !req.address[15] && !req.address[1];
    assign ula_hit    = !req.address[0];

    always_comb begin
        case (slot)
            2'd0:    bank = {2'b00, cur.paging[PG_ROM]};
            2'd1:    bank = SLOT1_BANK;
            2'd2:    bank = SLOT2_BANK;
            default: bank = cur.paging[2:0];
        endcase
    end

    always_comb begin
        kbd = 8'hFF;
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (!req.address[8+i]) begin
                kbd = kbd & req.key_rows[8*i +: 8];
            end
        end
    end

    always_comb begin
        nxt               = cur;
        rsp.is_rom        = 1'b0;
        rsp.phys_address  = '0;
        rsp.write_enable  = 1'b0;
        rsp.screen_write  = 1'b0;
        rsp.port_read_data = 8'hFF;
        unique case (req.operation)
            OP_MEM_READ, OP_MEM_WRITE: begin
                rsp.is_rom       = (slot == 2'd0);
                rsp.phys_address = {bank, offset};
                if (req.operation == OP_MEM_WRITE) begin
                    rsp.write_enable = (slot != 2'd0);
                    rsp.screen_write = (slot != 2'd0) && (bank == shown)
                                       && (offset < SCREEN_BYTES);
                end
            end
            OP_PORT_WRITE: begin
                if (paging_hit && !cur.paging[PG_LOCK]) begin
                    nxt.paging = req.write_data;
                end
                if (ula_hit) begin
                    nxt.border = req.write_data[2:0];
                    nxt.beeper = req.write_data[ULA_BEEP];
                end
            end
            OP_PORT_READ: begin
                if (ula_hit) begin
                    rsp.port_read_data = kbd;
                end
            end
            default: begin
                rsp.port_read_data = 8'hFF;
            end
        endcase
        rsp.shadow_screen = nxt.paging[PG_SHADOW];
        rsp.border_colour = nxt.border;
        rsp.beeper_level  = nxt.beeper;
        rsp.paging_locked = nxt.paging[PG_LOCK];
    end

endmodule

// File: rtl/core/bank_switched_memory_mapper.sv
// Bank switched memory mapper top level: request register, decode, state
// registers and response register. Uses bsmm_pkg and bsmm_decode.
//
// Takes one CPU bus request per cycle while the response side is not stalled,
// and returns one response per request: each request is held in the request
// register, then its response in the response register, with the
// whole translation done by the single decode stage between them. A request
// may be accepted while a finished response waits. Paging, border and beeper
// registers reset to 0, 2 and 0, and the state fields of each response show
// the state after that request.
module bank_switched_memory_mapper (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bsmm_pkg::bsmm_req_t  s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bsmm_pkg::bsmm_rsp_t  m_rsp
);
    import bsmm_pkg::*;

    logic        in_valid_reg;
    bsmm_req_t   in_req_reg;
    logic        out_valid_reg;
    bsmm_rsp_t   out_rsp_reg;
    bsmm_state_t state_reg;
    bsmm_state_t state_next;
    bsmm_rsp_t   rsp_next;
    logic        advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_rsp   = out_rsp_reg;

    bsmm_decode u_decode (
        .req (in_req_reg),
        .cur (state_reg),
        .nxt (state_next),
        .rsp (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.paging <= '0;
            state_reg.border <= BORDER_RESET;
            state_reg.beeper <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg <= s_req;
        end
        if (in_valid_reg && advance) begin
            out_rsp_reg <= rsp_next;
        end
    end

endmodule

// File: rtl/core/bsmm_checker.sv
// Port-level checker for bank_switched_memory_mapper and its bind.
// Uses bsmm_pkg types.
module bsmm_port_props (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bsmm_pkg::bsmm_rsp_t m_rsp
);

    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("response changed while stalled");

    a_no_rom_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.write_enable |-> !m_rsp.is_rom)
        else $error("write enabled into ROM slot");

    a_rom_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.is_rom |-> m_rsp.phys_address[16:15] == 2'b00)
        else $error("ROM address beyond bank 1");

    a_screen_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.screen_write |-> m_rsp.write_enable)
        else $error("screen write without write enable");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid after reset");

endmodule

bind bank_switched_memory_mapper bsmm_port_props u_bsmm_port_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);
